// ===== sv/shuffle_bag_dealer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Shuffle bag dealer assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SHUFFLE_BAG_DEALER_UNIT_ASSERT_SVH
`define SHUFFLE_BAG_DEALER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst
`define SBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define SBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/sbd_pkg.sv =====
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared types and constants of the shuffle bag dealer.
// ----------------------------------------------------------------------------
package sbd_pkg;

  // Default bag depth and the widths derived from it
  localparam int MAX_ENTRIES_DEF = 512;
  localparam int POS_W_DEF       = $clog2(MAX_ENTRIES_DEF + 1);

  // Fixed field widths
  localparam int CFG_W   = 10;
  localparam int RAND_W  = 32;
  localparam int INDEX_W = 9;
  localparam int STEP_W  = $clog2(RAND_W);

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_DSTART,
    S_DIV,
    S_RDK,
    S_RDJ,
    S_WRK,
    S_WRJ,
    S_RDL,
    S_WRL,
    S_WRL2,
    S_DONE
  } state_t;

  // Status of the remainder unit
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== sv/shuffle_bag_dealer_unit.sv =====
// ----------------------------------------------------------------------------
// shuffle_bag_dealer_unit
// Deals entry indices from a shuffle bag, one per request, using one
// random word per deal (forward Fisher-Yates over the configured count).
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall) carries random_word. Response
//   channel (rsp_valid / rsp_stall) carries dealt_index and deal_valid, one
//   response per request. A transfer happens when valid is high and stall
//   is low. cfg_we with cfg_wdata writes entry_count and starts a new round
//   at the next deal; write it only while no request is in flight.
//   A deal runs the 32-step remainder unit (one bit per cycle), then the
//   slot read and write steps on the bag memory, which has one write port
//   and one registered read port; the first deal of a round adds a second
//   swap when its pick would repeat the last index dealt. The first deal of
//   a round also refills the bag, one slot per cycle. A zero count goes
//   straight to the done state and answers with deal_valid low.
//   One request is worked at a time; req_stall is high until the sequencer
//   is back to idle. The result sits in an output register; while the
//   receiver stalls, the result holds and the sequencer waits for it.
//   Reset clears the count to zero and forces a refill at the first deal;
//   the bag memory itself needs no clearing.
// ----------------------------------------------------------------------------
module shuffle_bag_dealer_unit
  import sbd_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [RAND_W-1:0]  random_word,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [INDEX_W-1:0] dealt_index,
  output logic               deal_valid
);

  localparam int SLOT_W = $clog2(MAX_ENTRIES);
  localparam int POS_W  = $clog2(MAX_ENTRIES + 1);
  localparam int CW     = (POS_W > CFG_W) ? POS_W : CFG_W;

  state_t state, state_next;

  logic [CFG_W-1:0]  entry_count;
  logic [POS_W-1:0]  pos;
  logic [SLOT_W-1:0] last_dealt;
  logic              last_known;
  logic [RAND_W-1:0] rnd;
  logic [SLOT_W-1:0] fill_cnt;
  logic [SLOT_W-1:0] j_idx;
  logic [SLOT_W-1:0] va;
  logic [SLOT_W-1:0] vb;
  logic [SLOT_W-1:0] res_pick;
  logic              res_ok;

  logic [CW-1:0]     cnt_ext;
  logic [POS_W-1:0]  n;
  logic [SLOT_W-1:0] n_last;
  logic              req_xfer;
  logic              out_free;
  logic              swap_edge;
  logic [SLOT_W+INDEX_W-1:0] pick_wide;

  // Bag memory and its port controls
  logic [SLOT_W-1:0] mem [MAX_ENTRIES];
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  logic [SLOT_W-1:0] mem_wdata;
  logic [SLOT_W-1:0] mem_raddr;
  logic [SLOT_W-1:0] rd_q;

  logic              div_start;
  div_stat_t         div_st;
  logic [POS_W-1:0]  div_rem;

  // Saturate the count to the bag depth
  always_comb begin
    cnt_ext = CW'(entry_count);
    n       = (cnt_ext > CW'(MAX_ENTRIES)) ? POS_W'(MAX_ENTRIES) : POS_W'(cnt_ext);
    n_last  = SLOT_W'(n - 1'b1);
  end

  assign req_xfer  = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign swap_edge = (pos == '0) && (n > POS_W'(1)) && last_known && (vb == last_dealt);

  // Remainder unit: rnd mod (n - pos)
  sbd_mod_unit #(
    .DIVISOR_W(POS_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rnd),
    .divisor  (n - pos),
    .stat     (div_st),
    .remainder(div_rem)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_xfer) begin
          if (n == '0) begin
            state_next = S_DONE;
          end else if (pos >= n) begin
            state_next = S_FILL;
          end else begin
            state_next = S_DSTART;
          end
        end
      end
      S_FILL: begin
        if (fill_cnt == n_last) begin
          state_next = S_DSTART;
        end
      end
      S_DSTART: state_next = S_DIV;
      S_DIV: begin
        if (div_st.done) begin
          state_next = S_RDK;
        end
      end
      S_RDK:  state_next = S_RDJ;
      S_RDJ:  state_next = S_WRK;
      S_WRK:  state_next = S_WRJ;
      S_WRJ:  state_next = swap_edge ? S_RDL : S_DONE;
      S_RDL:  state_next = S_WRL;
      S_WRL:  state_next = S_WRL2;
      S_WRL2: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory port, divider start, request stall
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill_cnt;
    mem_wdata = fill_cnt;
    mem_raddr = pos[SLOT_W-1:0];
    div_start = 1'b0;
    req_stall = (state != S_IDLE);
    case (state)
      S_FILL: begin
        mem_we = 1'b1;
      end
      S_DSTART: div_start = 1'b1;
      S_RDK:    mem_raddr = pos[SLOT_W-1:0];
      S_RDJ:    mem_raddr = j_idx;
      S_WRK: begin
        mem_we    = 1'b1;
        mem_waddr = pos[SLOT_W-1:0];
        mem_wdata = rd_q;
      end
      S_WRJ: begin
        mem_we    = 1'b1;
        mem_waddr = j_idx;
        mem_wdata = va;
      end
      S_RDL:    mem_raddr = n_last;
      S_WRL: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = rd_q;
      end
      S_WRL2: begin
        mem_we    = 1'b1;
        mem_waddr = n_last;
        mem_wdata = vb;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Bag memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      pos         <= POS_W'(MAX_ENTRIES);
      last_dealt  <= '0;
      last_known  <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      // Load the response, or drop it once transferred
      if (state == S_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      // Configuration write restarts the bag
      if (cfg_we) begin
        entry_count <= cfg_wdata;
        pos         <= POS_W'(MAX_ENTRIES);
        last_known  <= 1'b0;
      end else if (state == S_FILL && fill_cnt == n_last) begin
        // Close the round fill
        pos <= '0;
      end else if (state == S_DONE && out_free && res_ok) begin
        // Commit the deal as the result is loaded
        last_dealt <= res_pick;
        last_known <= 1'b1;
        pos        <= pos + 1'b1;
      end
    end
  end

  // Working registers of the deal
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        rnd      <= random_word;
        fill_cnt <= '0;
        res_ok   <= 1'b0;
        res_pick <= '0;
      end
      S_FILL:  fill_cnt <= fill_cnt + 1'b1;
      S_DIV: begin
        if (div_st.done) begin
          j_idx <= SLOT_W'(pos + div_rem);
        end
      end
      S_RDJ:   va <= rd_q;
      S_WRK:   vb <= rd_q;
      S_WRJ: begin
        res_pick <= vb;
        res_ok   <= 1'b1;
      end
      S_WRL:   res_pick <= rd_q;
      default: begin
        res_ok <= res_ok;
      end
    endcase
  end

  // Output register payload
  assign pick_wide = {{INDEX_W{1'b0}}, res_pick};

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      dealt_index <= pick_wide[INDEX_W-1:0];
      deal_valid  <= res_ok;
    end
  end

  // Checks
  `include "shuffle_bag_dealer_unit_assert.svh"

  `SBD_ASSERT_NOW(a_empty_zero, rsp_valid && !deal_valid, dealt_index == '0, "empty deal carries nonzero index")
  `SBD_ASSERT_NEXT(a_accept_busy, req_xfer, state != S_IDLE, "accepted request left sequencer idle")
  `SBD_ASSERT_NOW(a_div_done_state, div_st.done, state == S_DIV, "remainder finished outside its wait state")
  `SBD_ASSERT_NOW(a_div_busy_state, div_st.busy, state == S_DIV, "remainder busy outside its wait state")

endmodule

// ===== sv/sbd_mod_unit.sv =====
// ----------------------------------------------------------------------------
// sbd_mod_unit
// Iterative remainder unit: one restoring step per cycle over the 32-bit
// random word, giving random_word mod divisor.
// ----------------------------------------------------------------------------
module sbd_mod_unit
  import sbd_pkg::*;
#(
  parameter int DIVISOR_W = POS_W_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [RAND_W-1:0]    dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output div_stat_t            stat,
  output logic [DIVISOR_W-1:0] remainder
);

  logic [RAND_W-1:0]    dvd;
  logic [DIVISOR_W-1:0] dsr;
  logic [DIVISOR_W-1:0] rem;
  logic [STEP_W-1:0]    step;
  logic                 busy;
  logic                 done;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem, dvd[RAND_W-1]};
    diff  = trial - {1'b0, dsr};
    fits  = (trial >= {1'b0, dsr});
  end

  // Control: busy over the steps, one-cycle done pulse after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(RAND_W - 1);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then advance one bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= dvd << 1;
      rem <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign stat      = '{busy: busy, done: done};
  assign remainder = rem;

endmodule

// ===== dv/tb_shuffle_bag_dealer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_shuffle_bag_dealer_unit
// Self-checking bench for the shuffle bag dealer. A behavioral copy of the
// bag predicts every dealt index; directed deals cover the corner cases
// and one long response hold-off, then random deals over many bag sizes
// run under three idling patterns.
// ----------------------------------------------------------------------------
module tb_shuffle_bag_dealer_unit;
  import sbd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BAG_DEPTH      = MAX_ENTRIES_DEF;
  localparam int STALL_LIMIT    = 6000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_DEALS   = 545;
  localparam logic [RAND_W-1:0] ALL_ONES = '1;

  typedef struct {
    logic [INDEX_W-1:0] index;
    logic               valid;
  } deal_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata = '0;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [RAND_W-1:0]  random_word = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b1;
  logic [INDEX_W-1:0] dealt_index;
  logic               deal_valid;

  // Shadow bag state
  logic [INDEX_W-1:0]   shadow_bag [BAG_DEPTH];
  logic [POS_W_DEF-1:0] shadow_pos = POS_W_DEF'(BAG_DEPTH);
  logic [INDEX_W-1:0]   shadow_last = '0;
  logic                 shadow_last_known = 1'b0;
  logic [CFG_W-1:0]     shadow_count = '0;

  deal_result_t owed_deals[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_gen = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  shuffle_bag_dealer_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .random_word (random_word),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .dealt_index (dealt_index),
    .deal_valid  (deal_valid)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Advance the shadow bag by one deal and return the index it deals
  function automatic deal_result_t shuffle_deal(input logic [RAND_W-1:0] word);
    deal_result_t       res;
    int unsigned        n;
    int unsigned        k;
    int unsigned        j;
    logic [INDEX_W-1:0] tmp;
    n = shadow_count;
    if (n > BAG_DEPTH) n = BAG_DEPTH;
    res.index = '0;
    res.valid = 1'b0;
    if (n == 0) return res;
    // Refill in order when the round is used up
    if (shadow_pos >= n) begin
      for (int i = 0; i < n; i++) shadow_bag[i] = INDEX_W'(i);
      shadow_pos = '0;
    end
    k = shadow_pos;
    j = k + word % (n - k);
    tmp = shadow_bag[k];
    shadow_bag[k] = shadow_bag[j];
    shadow_bag[j] = tmp;
    // Keep the first pick of a round from repeating the last one dealt
    if (k == 0 && n > 1 && shadow_last_known && shadow_bag[0] == shadow_last) begin
      tmp = shadow_bag[0];
      shadow_bag[0] = shadow_bag[n-1];
      shadow_bag[n-1] = tmp;
    end
    res.index = shadow_bag[k];
    res.valid = 1'b1;
    shadow_last = res.index;
    shadow_last_known = 1'b1;
    shadow_pos = POS_W_DEF'(k + 1);
    return res;
  endfunction

  // Offer one random word and record the deal it must produce
  task automatic deal_one(input logic [RAND_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    random_word <= word;
    do @(posedge clk); while (req_stall);
    owed_deals.push_back(shuffle_deal(word));
  endtask

  // Drop the request and wait until every deal has come back
  task automatic drain_deals();
    req_valid <= 1'b0;
    while (owed_deals.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write the entry count while the block is idle
  task automatic load_entry_count(input logic [CFG_W-1:0] count);
    drain_deals();
    cfg_we <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    shadow_count = count;
    shadow_pos = POS_W_DEF'(BAG_DEPTH);
    shadow_last_known = 1'b0;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [RAND_W-1:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return RAND_W'($urandom_range(15));
      default: return RAND_W'($urandom);
    endcase
  endfunction

  // Mostly small bags so rounds wrap often; a few large and saturated ones
  function automatic logic [CFG_W-1:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 4)  return '0;
    if (r < 8)  return CFG_W'(1);
    if (r < 12) return CFG_W'(2);
    if (r < 70) return CFG_W'($urandom_range(3, 12));
    if (r < 85) return CFG_W'($urandom_range(13, 64));
    if (r < 93) return CFG_W'($urandom_range(65, 511));
    if (r < 96) return CFG_W'(BAG_DEPTH);
    return CFG_W'($urandom_range(513, 1023));
  endfunction

  // Count zero straight out of reset: no index is dealt
  task automatic test_zero_count();
    deal_one('0);
    deal_one(ALL_ONES);
  endtask

  // One entry: index zero every time
  task automatic test_single_entry();
    load_entry_count(CFG_W'(1));
    deal_one('0);
    deal_one(ALL_ONES);
    deal_one(32'hA5A5_A5A5);
  endtask

  // Two entries: a round boundary where the first pick repeats the last one
  task automatic test_round_boundary();
    load_entry_count(CFG_W'(2));
    deal_one(32'd1);
    deal_one(32'd7);
    deal_one('0);
    deal_one(ALL_ONES);
    deal_one(32'd1);
    deal_one('0);
  endtask

  // Oversized count, full-size bag and a rewrite in the middle of a round
  task automatic test_count_limits();
    load_entry_count('1);
    deal_one('0);
    deal_one(ALL_ONES);
    deal_one(32'h8000_0001);
    load_entry_count(CFG_W'(BAG_DEPTH));
    deal_one(ALL_ONES);
    deal_one(32'h5555_5555);
    load_entry_count(CFG_W'(3));
    deal_one(32'd2);
    deal_one(32'd1);
    load_entry_count(CFG_W'(3));
    deal_one(32'd2);
    deal_one(ALL_ONES);
  endtask

  // Hold the response side off while requests keep coming
  task automatic test_backpressure();
    load_entry_count(CFG_W'(5));
    hold_gen++;
    for (int i = 0; i < 6; i++) deal_one(pick_word());
  endtask

  // Random bag sizes; bags of up to 64 entries get up to three rounds and two deals
  task automatic test_random_deals(input int send_pct, input int recv_pct);
    int left;
    int n_eff;
    int burst;
    logic [CFG_W-1:0] count;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    left = RANDOM_DEALS;
    while (left > 0) begin
      count = pick_count();
      load_entry_count(count);
      n_eff = (count > BAG_DEPTH) ? BAG_DEPTH : count;
      if (n_eff == 0) burst = $urandom_range(1, 4);
      else if (n_eff <= 64) burst = $urandom_range(1, 3 * n_eff + 2);
      else burst = $urandom_range(1, 40);
      if (burst > left) burst = left;
      for (int i = 0; i < burst; i++) deal_one(pick_word());
      left -= burst;
    end
  endtask

  // Drain and report
  task automatic test_wrap_up();
    drain_deals();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("shuffle_bag_dealer_unit: match");
    end else begin
      $display("shuffle_bag_dealer_unit: mismatch");
    end
    $finish;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_zero_count();
    test_single_entry();
    test_round_boundary();
    test_count_limits();
    test_backpressure();
    test_random_deals(36, 72);
    test_random_deals(72, 36);
    test_random_deals(0, 0);
    test_wrap_up();
  end

  // Receiver: long hold-off on request, otherwise random stalls
  always @(posedge clk) begin
    if (hold_gen != hold_seen) begin
      hold_seen = hold_gen;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each response transfer with the oldest owed deal
  always @(posedge clk) begin
    deal_result_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (owed_deals.size() == 0) begin
        $error("unexpected response: dealt_index %0d deal_valid %0b", dealt_index, deal_valid);
        mismatches++;
      end else begin
        want = owed_deals.pop_front();
        if (deal_valid !== want.valid) begin
          $error("deal_valid: expected %0b, got %0b", want.valid, deal_valid);
          mismatches++;
        end
        if (dealt_index !== want.index) begin
          $error("dealt_index: expected %0d, got %0d", want.index, dealt_index);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("shuffle_bag_dealer_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
